/* hw/rtl/bitmap_range_allocator_assert.svh */
// Assertion macros for the bitmap range allocator
`ifndef BITMAP_RANGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_RANGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bra assertion failed");

// next-cycle implication, disabled in reset
`define BRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bra assertion failed");

`endif

/* hw/rtl/bra_pkg.sv */
// Shared types and constants of the bitmap range allocator
`timescale 1ns / 1ps
package bra_pkg;
    localparam int MAX_WORDS_DEF = 64;
    localparam int OP_W   = 3;
    localparam int BASE_W = 12;
    localparam int LEN_W  = 13;
    localparam int CFG_W  = 7;
    localparam int STAT_W = 2;
    localparam int POS_W  = 12;
    localparam int FW     = 8;

    localparam logic [OP_W-1:0] OP_SET    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLR    = 3'd1;
    localparam logic [OP_W-1:0] OP_FFZ    = 3'd2;
    localparam logic [OP_W-1:0] OP_FLZ    = 3'd3;
    localparam logic [OP_W-1:0] OP_FRUN   = 3'd4;
    localparam logic [OP_W-1:0] OP_LRUN   = 3'd5;
    localparam logic [OP_W-1:0] OP_LALIGN = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd2;

    localparam logic [CFG_W-1:0] WORDS_RST = 7'd64;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISP, S_RMW_RD, S_RMW_WR, S_FIND, S_DRAIN, S_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rmw_rd;
        logic rmw_wr;
        logic scan;
        logic resp;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rmw_last;
        logic scan_last;
        logic range_err;
        logic nop;
        logic find;
        logic pipe_idle;
        logic out_free;
    } t_sts;
endpackage

/* hw/rtl/bra_cmd_if.sv */
// Command channel interface
`timescale 1ns / 1ps
interface bra_cmd_if import bra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BASE_W-1:0] base_bit;
    logic [LEN_W-1:0]  run_length;
    logic [LEN_W-1:0]  align_bits;

    modport source (output valid, op, base_bit, run_length, align_bits, input ready);
    modport sink (input valid, op, base_bit, run_length, align_bits, output ready);
endinterface

/* hw/rtl/bra_res_if.sv */
// Result channel interface
`timescale 1ns / 1ps
interface bra_res_if import bra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;

    modport source (output valid, status, position, input ready);
    modport sink (input valid, status, position, output ready);
endinterface

/* hw/rtl/bra_ctrl.sv */
// Controller state machine of the bitmap range allocator
`timescale 1ns / 1ps
module bra_ctrl import bra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_sts i_sts,
    output logic o_cmd_ready,
    output t_cmd o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_sts.range_err || i_sts.nop) n_state = S_DONE;
                else if (i_sts.find) n_state = S_FIND;
                else n_state = S_RMW_RD;
            end
            S_RMW_RD: begin
                o_ctl.rmw_rd = 1'b1;
                n_state      = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_ctl.rmw_wr = 1'b1;
                n_state      = i_sts.rmw_last ? S_DONE : S_RMW_RD;
            end
            S_FIND: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.pipe_idle) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* hw/rtl/bra_dp.sv */
// Datapath of the bitmap range allocator: bitmap memory, scan pipeline, result register
`timescale 1ns / 1ps
`include "bitmap_range_allocator_assert.svh"
module bra_dp import bra_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_ctl,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BASE_W-1:0] i_base_bit,
    input  logic [LEN_W-1:0]  i_run_length,
    input  logic [LEN_W-1:0]  i_align_bits,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_position
);
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int EW = (CW + 6 > LEN_W + 1) ? CW + 6 : LEN_W + 1;
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam int PW = AW + 6;
    localparam int GW = ((AW > FW) ? AW : FW) + 1;
    localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_WORDS - 1);

    function automatic logic [5:0] f_lsb(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int k = 63; k >= 0; k--) if (v[k]) r = 6'(k);
        return r;
    endfunction

    function automatic logic [5:0] f_msb(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 64; k++) if (v[k]) r = 6'(k);
        return r;
    endfunction

    logic [CFG_W-1:0] r_words;
    logic [CW-1:0]    w_nw;
    logic [EW-1:0]    w_max_bit, w_end;
    logic             w_range, w_is_rmw, w_is_find, w_is_bit;
    logic [LEN_W-1:0] w_rl;
    logic [FW-1:0]    w_fr, w_af;

    // item registers
    logic [OP_W-1:0] r_op;
    logic            r_range, r_nop, r_find, r_first, r_single, r_op6;
    logic [AW-1:0]   r_first_w, r_last_w, r_addr;
    logic [5:0]      r_lo, r_hi;
    logic [FW-1:0]   r_fr, r_af, r_cnt, r_srem;
    logic [6:0]      r_rl7;

    logic [63:0] r_mem [MAX_WORDS];
    logic [63:0] r_rdata, w_wdata, w_mask;
    logic [5:0]  w_lo_eff, w_hi_eff;
    logic        w_we;

    logic          r_v1, r_v2, r_wz, r_found;
    logic [AW-1:0] r_w1, r_w2, w_start;
    logic [63:0]   r_cand, w_cand;
    logic [63:0]   w_run [7];
    logic [6:0]    w_sh;
    logic [FW-1:0] w_cnt_n;
    logic          w_hit, w_in_rng, w_rec;
    logic [PW-1:0] r_pos, w_pos;
    logic [5:0]    w_off;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [POS_W-1:0]  r_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= WORDS_RST;
        end else if (i_cfg_we) begin
            r_words <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_words == '0) begin
            w_nw = CW'(1);
        end else if (XW'(r_words) > XW'(MAX_WORDS)) begin
            w_nw = CW'(MAX_WORDS);
        end else begin
            w_nw = CW'(r_words);
        end
    end

    assign w_max_bit = (EW'(w_nw) << 6) - EW'(1);
    assign w_end     = EW'(i_base_bit) + EW'(i_run_length) - EW'(1);
    assign w_is_rmw  = (i_op == OP_SET) || (i_op == OP_CLR);
    assign w_is_find = !w_is_rmw && (i_op != OP_NOP);
    assign w_is_bit  = (i_op == OP_FFZ) || (i_op == OP_FLZ);
    assign w_range   = w_is_rmw && ((EW'(i_base_bit) > w_max_bit) ||
                       ((i_run_length != '0) && (w_end > w_max_bit)));
    assign w_rl      = (w_is_bit || i_run_length == '0) ? LEN_W'(1) : i_run_length;
    assign w_fr      = FW'((LEN_W'(w_rl) + LEN_W'(63)) >> 6) |
                       FW'(w_rl > LEN_W'(8128) ? 128 : 0);
    assign w_af      = (i_align_bits == '0) ? FW'(1) :
                       (FW'((i_align_bits + LEN_W'(63)) >> 6) |
                        FW'(i_align_bits > LEN_W'(8128) ? 128 : 0));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op      <= i_op;
            r_range   <= w_range;
            r_nop     <= (i_op == OP_NOP) || (w_is_rmw && i_run_length == '0);
            r_find    <= w_is_find;
            r_first   <= (i_op == OP_FFZ) || (i_op == OP_FRUN);
            r_single  <= (w_fr == FW'(1)) && (i_op != OP_LALIGN);
            r_op6     <= (i_op == OP_LALIGN);
            r_first_w <= AW'(i_base_bit >> 6);
            r_last_w  <= AW'(w_end >> 6);
            r_lo      <= i_base_bit[5:0];
            r_hi      <= w_end[5:0];
            r_fr      <= w_fr;
            r_af      <= w_af;
            r_rl7     <= w_rl[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_ctl.load) begin
            r_addr <= w_is_find ? '0 : AW'(i_base_bit >> 6);
        end else if (i_ctl.clr_step || i_ctl.rmw_wr || i_ctl.scan) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    assign w_lo_eff = (r_addr == r_first_w) ? r_lo : 6'd0;
    assign w_hi_eff = (r_addr == r_last_w) ? r_hi : 6'd63;
    assign w_mask   = ({64{1'b1}} << w_lo_eff) & ({64{1'b1}} >> (6'd63 - w_hi_eff));
    assign w_we     = i_ctl.clr_step || i_ctl.rmw_wr;
    assign w_wdata  = i_ctl.clr_step ? 64'd0 :
                      ((r_op == OP_SET) ? (r_rdata | w_mask) : (r_rdata & ~w_mask));

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_addr] <= w_wdata;
        r_rdata <= r_mem[r_addr];
    end

    // clear-run candidates of the current word
    always_comb begin
        w_run[0] = ~r_rdata;
        for (int j = 1; j < 7; j++) begin
            w_run[j] = w_run[j-1] & (w_run[j-1] >> (1 << (j - 1)));
        end
        w_cand = '1;
        w_sh   = '0;
        for (int j = 0; j < 7; j++) begin
            if (r_rl7[j]) begin
                w_cand = w_cand & (w_run[j] >> w_sh);
                w_sh   = w_sh + 7'(1 << j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.scan;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1 <= r_addr;
        if (r_v1) begin
            r_cand <= w_cand;
            r_wz   <= (r_rdata == 64'd0);
            r_w2   <= r_w1;
        end
    end

    assign w_cnt_n  = r_wz ? ((r_cnt == '1) ? r_cnt : r_cnt + FW'(1)) : '0;
    assign w_in_rng = (GW'(r_w2) + GW'(1)) >= GW'(r_fr);
    assign w_start  = r_w2 - AW'(r_fr - FW'(1));
    assign w_off    = r_first ? f_lsb(r_cand) : f_msb(r_cand);

    always_comb begin
        if (r_single) begin
            w_hit = (r_cand != 64'd0);
            w_pos = {r_w2, w_off};
        end else begin
            w_hit = (w_cnt_n >= r_fr) && (!r_op6 || r_srem == '0);
            w_pos = {w_start, 6'd0};
        end
    end

    assign w_rec = r_v2 && w_hit && (!r_first || !r_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.load) begin
            r_found <= 1'b0;
        end else if (w_rec) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cnt  <= '0;
            r_srem <= '0;
        end else if (r_v2) begin
            r_cnt <= w_cnt_n;
            if (w_in_rng) r_srem <= (r_srem == r_af - FW'(1)) ? '0 : r_srem + FW'(1);
        end
        if (w_rec) r_pos <= w_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.resp) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.resp) begin
            r_status   <= r_range ? ST_RANGE : ((r_find && !r_found) ? ST_NONE : ST_OK);
            r_position <= (r_find && r_found) ? POS_W'(r_pos) : '0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;

    assign o_sts.clr_last  = (r_addr == ADDR_TOP);
    assign o_sts.rmw_last  = (r_addr == r_last_w);
    assign o_sts.scan_last = (r_addr == AW'(w_nw - CW'(1)));
    assign o_sts.range_err = r_range;
    assign o_sts.nop       = r_nop;
    assign o_sts.find      = r_find;
    assign o_sts.pipe_idle = !r_v1 && !r_v2;
    assign o_sts.out_free  = !r_out_valid || i_res_ready;

    `BRA_ASSERT_NXT(a_resp_valid, i_clk, i_rst_n, i_ctl.resp, r_out_valid)
    `BRA_ASSERT_IMP(a_resp_free, i_clk, i_rst_n, i_ctl.resp, !r_out_valid || i_res_ready)
    `BRA_ASSERT_IMP(a_rmw_order, i_clk, i_rst_n, i_ctl.rmw_wr, $past(i_ctl.rmw_rd))
    `BRA_ASSERT_IMP(a_pipe_order, i_clk, i_rst_n, r_v2, $past(r_v1))
endmodule

/* hw/rtl/bitmap_range_allocator.sv */
// Bitmap range allocator top level
// After reset the block sweeps all MAX_WORDS words of the bitmap memory to zero, one word per
// cycle, and takes no item meanwhile. Set and clear read and then write back each word the range
// touches; a find reads every managed word once through the single read port of the bitmap
// memory.
// One item is worked at a time; the result register lets the next item in while a result waits.
`timescale 1ns / 1ps
module bitmap_range_allocator import bra_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bra_cmd_if.sink          i_cmd,
    bra_res_if.source        o_res
);
    t_cmd w_ctl;
    t_sts w_sts;
    logic w_ready;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_sts       (w_sts),
        .o_cmd_ready (w_ready),
        .o_ctl       (w_ctl)
    );

    bra_dp #(.MAX_WORDS(MAX_WORDS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_cmd.op),
        .i_base_bit   (i_cmd.base_bit),
        .i_run_length (i_cmd.run_length),
        .i_align_bits (i_cmd.align_bits),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_status     (o_res.status),
        .o_position   (o_res.position)
    );

    assign i_cmd.ready = w_ready;
endmodule

/* dv/bitmap_range_allocator_chk.sv */
// Checker for the bitmap range allocator: bitmap model, expected results and comparison
`timescale 1ns / 1ps
module bitmap_range_allocator_chk import bra_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bra_cmd_if.sink          i_cmd,
    bra_res_if.sink          i_res,
    output int               o_fail_cnt,
    output int               o_pending
);
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
    } t_result;

    logic [63:0]      bmap [64];
    logic [CFG_W-1:0] words_cfg;
    t_result          result_q [$];
    int               mismatch_cnt;

    assign o_fail_cnt = mismatch_cnt;
    assign o_pending  = result_q.size();

    function automatic int word_run_off(logic [63:0] w, int len, bit from_top);
        logic [63:0] m;
        int span;
        int off;
        m = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
        span = 64 - len;
        for (int k = 0; k <= span; k++) begin
            off = from_top ? span - k : k;
            if (((w >> off) & m) == 64'd0) return off;
        end
        return -1;
    endfunction

    function automatic bit span_clear(int first, int cnt);
        for (int k = 0; k < cnt; k++)
            if (bmap[first + k] != 64'd0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result predict_alloc(logic [OP_W-1:0] op, int base, int len, int align);
        t_result r;
        int nw, max_bit, rl, frames, top, af, s, wi, off, pos;
        bit found;
        nw = (words_cfg == 0) ? 1 : (words_cfg > 64 ? 64 : int'(words_cfg));
        max_bit = nw * 64 - 1;
        r.status = ST_OK;
        pos = 0;
        found = 0;
        if (op == OP_SET || op == OP_CLR) begin
            if (base > max_bit || (len != 0 && base + len - 1 > max_bit)) begin
                r.status = ST_RANGE;
            end else begin
                for (int b = base; b < base + len; b++)
                    bmap[b >> 6][b & 63] = (op == OP_SET);
            end
        end else if (op != OP_NOP) begin
            rl = (len == 0) ? 1 : len;
            frames = (rl + 63) / 64;
            r.status = ST_NONE;
            if (op == OP_FFZ || op == OP_FLZ) begin
                for (int i = 0; i < nw && !found; i++) begin
                    wi = (op == OP_FFZ) ? i : nw - 1 - i;
                    off = word_run_off(bmap[wi], 1, op == OP_FLZ);
                    if (off >= 0) begin found = 1; pos = wi * 64 + off; end
                end
            end else if (frames <= nw) begin
                top = nw - frames;
                if (op == OP_LALIGN) begin
                    af = (align == 0) ? 1 : (align + 63) / 64;
                    s = top - top % af;
                    forever begin
                        if (span_clear(s, frames)) begin found = 1; pos = s * 64; break; end
                        if (s < af) break;
                        s -= af;
                    end
                end else begin
                    for (int i = 0; i <= top && !found; i++) begin
                        wi = (op == OP_FRUN) ? i : top - i;
                        if (frames > 1) begin
                            if (span_clear(wi, frames)) begin found = 1; pos = wi * 64; end
                        end else begin
                            off = word_run_off(bmap[wi], rl, op == OP_LRUN);
                            if (off >= 0) begin found = 1; pos = wi * 64 + off; end
                        end
                    end
                end
            end
            if (found) r.status = ST_OK;
            else pos = 0;
        end
        r.position = pos[POS_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            foreach (bmap[i]) bmap[i] = '0;
            words_cfg = WORDS_RST;
            result_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_cfg_we) words_cfg = i_cfg_wdata;
            if (i_cmd.valid && i_cmd.ready)
                result_q.push_back(predict_alloc(i_cmd.op, int'(i_cmd.base_bit),
                                                 int'(i_cmd.run_length),
                                                 int'(i_cmd.align_bits)));
            if (i_res.valid && i_res.ready) begin
                if (result_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected result st=%0d pos=%0d",
                                                     i_res.status, i_res.position);
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.status !== i_res.status || exp_r.position !== i_res.position) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp st=%0d pos=%0d, got st=%0d pos=%0d",
                                     exp_r.status, exp_r.position, i_res.status, i_res.position);
                    end
                end
            end
        end
    end
endmodule

/* dv/bitmap_range_allocator_tb.sv */
// Testbench top for the bitmap range allocator: stimulus, configuration and verdict
`timescale 1ns / 1ps
module bitmap_range_allocator_tb;
    import bra_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    int               fail_cnt;
    int               pending;
    int               cycle_cnt;
    bit               calm;

    bra_cmd_if cmd_ch ();
    bra_res_if res_ch ();

    bitmap_range_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    bitmap_range_allocator_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_cmd(cmd_ch.sink), .i_res(res_ch.sink), .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 16);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // valid stays high into the next item unless a gap or a drain follows
    task automatic send_item(logic [OP_W-1:0] op, logic [BASE_W-1:0] base,
                             logic [LEN_W-1:0] len, logic [LEN_W-1:0] align);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.base_bit   <= base;
        cmd_ch.run_length <= len;
        cmd_ch.align_bits <= align;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_all();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_words(logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 5))
            0: return LEN_W'($urandom_range(0, 8191));
            1: return LEN_W'($urandom_range(65, 600));
            2: return LEN_W'($urandom_range(0, 70));
            default: return LEN_W'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic rand_item(int nw);
        logic [OP_W-1:0] op;
        int base;
        op = OP_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 4095);
        else base = $urandom_range(0, nw * 64 - 1);
        send_item(op, BASE_W'(base), rand_len(), LEN_W'($urandom_range(0, 8191)));
    endtask

    initial begin
        logic [CFG_W-1:0] cfgs [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd17};
        int nw;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op = OP_NOP;
        cmd_ch.base_bit = '0;
        cmd_ch.run_length = '0;
        cmd_ch.align_bits = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_words(7'd64);

        // directed
        send_item(OP_FFZ, 0, 1, 1);
        send_item(OP_SET, 0, 0, 0);
        send_item(OP_SET, 0, 70, 0);
        send_item(OP_FFZ, 0, 0, 0);
        send_item(OP_SET, 12'd4095, 1, 0);
        send_item(OP_FLZ, 0, 0, 0);
        send_item(OP_SET, 12'd4000, 200, 0);
        send_item(OP_CLR, 12'd4095, 0, 0);
        send_item(OP_FRUN, 0, 0, 0);
        send_item(OP_FRUN, 0, 64, 0);
        send_item(OP_LRUN, 0, 13'd4096, 0);
        send_item(OP_LRUN, 0, 8191, 0);
        send_item(OP_LRUN, 0, 30, 0);
        send_item(OP_LALIGN, 0, 128, 0);
        send_item(OP_LALIGN, 0, 65, 13'd4096);
        send_item(OP_LALIGN, 0, 1, 8191);
        send_item(OP_NOP, 12'd4095, 8191, 8191);
        send_item(OP_CLR, 0, 13'd4096, 0);
        send_item(OP_SET, 0, 13'd4096, 0);
        send_item(OP_FFZ, 0, 1, 1);
        send_item(OP_FLZ, 0, 1, 1);
        send_item(OP_LALIGN, 0, 1, 64);
        send_item(OP_CLR, 100, 50, 0);
        send_item(OP_FRUN, 0, 50, 0);
        drain_all();

        for (int p = 0; p < 6; p++) begin
            write_words(cfgs[p]);
            nw = (cfgs[p] == 0) ? 1 : (cfgs[p] > 64 ? 64 : int'(cfgs[p]));
            if (p == 5) calm = 1'b1;
            for (int i = 0; i < 330; i++) begin
                // mostly allocate/find/free traffic against the managed range
                if (i % 40 == 39) send_item(OP_CLR, 0, 13'(nw * 64), 0);
                rand_item(nw);
            end
            drain_all();
        end

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bra_pkg.sv
hw/rtl/bra_cmd_if.sv
hw/rtl/bra_res_if.sv
hw/rtl/bra_ctrl.sv
hw/rtl/bra_dp.sv
hw/rtl/bitmap_range_allocator.sv
dv/bitmap_range_allocator_chk.sv
dv/bitmap_range_allocator_tb.sv
